// ===== src/mbbox_pkg.sv =====
// ----------------------------------------------------------------------------
// mbbox_pkg
// Shared types, constants and helpers for the mask bounding box crop core.
// ----------------------------------------------------------------------------
package mbbox_pkg;

	// largest image or mask dimension
	localparam int MAX_DIM = 4096;
	// width of a column or row coordinate
	localparam int COORD_W = $clog2(MAX_DIM);
	// width of a dimension register, holds MAX_DIM itself
	localparam int DIM_W   = COORD_W + 1;
	// signed width of an edge after widening, before the clamp
	localparam int EDGE_W  = COORD_W + 2;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_FIXED_ASPECT = 2'd0,
		CFG_MASK_WIDTH   = 2'd1,
		CFG_IMAGE_WIDTH  = 2'd2,
		CFG_IMAGE_HEIGHT = 2'd3
	} cfg_idx_t;

	// running or final bounding box of one frame
	typedef struct packed {
		logic               any_seen;
		logic [COORD_W-1:0] min_col;
		logic [COORD_W-1:0] max_col;
		logic [COORD_W-1:0] min_row;
		logic [COORD_W-1:0] max_row;
	} box_t;

	// zero or out of range dimension behaves as the largest one
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0 || v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// clamp a signed edge into [0, hi]
	function automatic logic [COORD_W-1:0] clamp_edge(
		input logic signed [EDGE_W-1:0] v,
		input logic        [COORD_W-1:0] hi
	);
		logic [COORD_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({2'b00, hi})) begin
			r = hi;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== src/mask_bounding_box_square_crop_core.sv =====
// ----------------------------------------------------------------------------
// mask_bounding_box_square_crop_core
// Bounding box of a raster-order binary mask, optionally squared and clamped
// to the image, reported once per frame.
// ----------------------------------------------------------------------------
// Throughput: one mask pixel per clock unless out_ready stalls, no frame gaps.
// Result path: the box of a frame is held in the box capture register once
//   its last pixel is taken, then squared and clamped into the result
//   register, which drives the outputs.
// Reset: counters and box clear, fixed_aspect = 1, every dimension = 4096.
module mask_bounding_box_square_crop_core
	import mbbox_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration writes
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [DIM_W-1:0]   cfg_wdata,
	// pixel requests
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mask_set,
	input  logic               frame_end,
	// crop results
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [COORD_W-1:0] left_edge,
	output logic [COORD_W-1:0] top_edge,
	output logic [COORD_W-1:0] right_edge,
	output logic [COORD_W-1:0] bottom_edge
);

	// configuration registers
	logic             fixed_aspect_q;
	logic [DIM_W-1:0] mask_width_q;
	logic [DIM_W-1:0] image_width_q;
	logic [DIM_W-1:0] image_height_q;

	// frame accumulation state
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	box_t               box_q;
	box_t               box_nxt;

	// captured box and result stage
	logic               valid_s1;
	box_t               box_s1;
	logic               valid_s2;
	logic               found_s2;
	logic [COORD_W-1:0] left_s2;
	logic [COORD_W-1:0] top_s2;
	logic [COORD_W-1:0] right_s2;
	logic [COORD_W-1:0] bottom_s2;

	logic             accept;
	logic             s1_ready;
	logic             s2_ready;
	logic [DIM_W-1:0] mw;
	logic             col_wrap;

	// squaring and clamp signals
	logic [COORD_W-1:0]       dx;
	logic [COORD_W-1:0]       dy;
	logic [COORD_W-1:0]       half_diff;
	logic                     taller;
	logic signed [EDGE_W-1:0] l_wide;
	logic signed [EDGE_W-1:0] r_wide;
	logic signed [EDGE_W-1:0] t_wide;
	logic signed [EDGE_W-1:0] b_wide;
	logic [DIM_W-1:0]         iw_m1;
	logic [DIM_W-1:0]         ih_m1;

	// handshake: the pipeline moves when the next stage has room
	assign s2_ready = !valid_s2 || out_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign in_ready = s1_ready;
	assign accept   = in_valid && in_ready;

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_aspect_q <= 1'b1;
			mask_width_q   <= DIM_W'(MAX_DIM);
			image_width_q  <= DIM_W'(MAX_DIM);
			image_height_q <= DIM_W'(MAX_DIM);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_FIXED_ASPECT: fixed_aspect_q <= cfg_wdata[0];
				CFG_MASK_WIDTH:   mask_width_q   <= cfg_wdata;
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	// column wrap at the effective mask width
	assign mw       = eff_dim(mask_width_q);
	assign col_wrap = ({1'b0, col_q} + DIM_W'(1)) >= mw;

	// min and max update for the current pixel
	always_comb begin
		box_nxt = box_q;
		if (mask_set) begin
			if (!box_q.any_seen) begin
				box_nxt.any_seen = 1'b1;
				box_nxt.min_col  = col_q;
				box_nxt.max_col  = col_q;
				box_nxt.min_row  = row_q;
				box_nxt.max_row  = row_q;
			end else begin
				if (col_q < box_q.min_col) box_nxt.min_col = col_q;
				if (col_q > box_q.max_col) box_nxt.max_col = col_q;
				if (row_q < box_q.min_row) box_nxt.min_row = row_q;
				if (row_q > box_q.max_row) box_nxt.max_row = row_q;
			end
		end
	end

	// frame accumulation, cleared after the last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q            <= '0;
			row_q            <= '0;
			box_q.any_seen   <= 1'b0;
			box_q.min_col    <= '1;
			box_q.max_col    <= '0;
			box_q.min_row    <= '1;
			box_q.max_row    <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q            <= '0;
				row_q            <= '0;
				box_q.any_seen   <= 1'b0;
				box_q.min_col    <= '1;
				box_q.max_col    <= '0;
				box_q.min_row    <= '1;
				box_q.max_row    <= '0;
			end else begin
				box_q <= box_nxt;
				if (col_wrap) begin
					col_q <= '0;
					if (row_q != '1) row_q <= row_q + COORD_W'(1);
				end else begin
					col_q <= col_q + COORD_W'(1);
				end
			end
		end
	end

	// box capture stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= accept && frame_end;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame_end) box_s1 <= box_nxt;
	end

	// squaring: widen the shorter side by half the difference on both ends
	assign dx     = box_s1.max_col - box_s1.min_col;
	assign dy     = box_s1.max_row - box_s1.min_row;
	assign taller = dy > dx;

	always_comb begin
		half_diff = taller ? ((dy - dx) >> 1) : ((dx - dy) >> 1);
		l_wide = $signed({2'b00, box_s1.min_col});
		r_wide = $signed({2'b00, box_s1.max_col});
		t_wide = $signed({2'b00, box_s1.min_row});
		b_wide = $signed({2'b00, box_s1.max_row});
		if (fixed_aspect_q) begin
			if (taller) begin
				l_wide = l_wide - $signed({2'b00, half_diff});
				r_wide = r_wide + $signed({2'b00, half_diff});
			end else begin
				t_wide = t_wide - $signed({2'b00, half_diff});
				b_wide = b_wide + $signed({2'b00, half_diff});
			end
		end
	end

	// last valid column and row of the image
	assign iw_m1 = eff_dim(image_width_q) - DIM_W'(1);
	assign ih_m1 = eff_dim(image_height_q) - DIM_W'(1);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			found_s2 <= box_s1.any_seen;
			if (box_s1.any_seen) begin
				left_s2   <= clamp_edge(l_wide, iw_m1[COORD_W-1:0]);
				right_s2  <= clamp_edge(r_wide, iw_m1[COORD_W-1:0]);
				top_s2    <= clamp_edge(t_wide, ih_m1[COORD_W-1:0]);
				bottom_s2 <= clamp_edge(b_wide, ih_m1[COORD_W-1:0]);
			end else begin
				left_s2   <= '0;
				right_s2  <= '0;
				top_s2    <= '0;
				bottom_s2 <= '0;
			end
		end
	end

	assign out_valid   = valid_s2;
	assign found       = found_s2;
	assign left_edge   = left_s2;
	assign top_edge    = top_s2;
	assign right_edge  = right_s2;
	assign bottom_edge = bottom_s2;

	// state is cleared after the last pixel of a frame
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_end |=> !box_q.any_seen && col_q == '0 && row_q == '0)
		else $error("frame state not cleared after last pixel");

	// a found box is never inverted
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> left_edge <= right_edge && top_edge <= bottom_edge)
		else $error("crop rectangle inverted");

	// an empty frame reports all edges zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> left_edge == '0 && top_edge == '0
			&& right_edge == '0 && bottom_edge == '0)
		else $error("empty frame with nonzero edges");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mask bounding box crop core. A queue of mask
// pixels feeds a valid/ready driver, a clocked monitor runs a local box
// predictor on every accepted pixel request and checks each crop result
// against the oldest prediction, across directed and random frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
	import mbbox_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic mask_set;
		logic frame_end;
	} pixel_t;

	typedef struct packed {
		logic               found;
		logic [COORD_W-1:0] left_edge;
		logic [COORD_W-1:0] top_edge;
		logic [COORD_W-1:0] right_edge;
		logic [COORD_W-1:0] bottom_edge;
	} crop_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_idx = CFG_FIXED_ASPECT;
	logic [DIM_W-1:0]   cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               mask_set = 1'b0;
	logic               frame_end = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               found;
	logic [COORD_W-1:0] left_edge;
	logic [COORD_W-1:0] top_edge;
	logic [COORD_W-1:0] right_edge;
	logic [COORD_W-1:0] bottom_edge;

	// pending pixel requests and predicted crops
	pixel_t pixel_q[$];
	crop_t  crop_q[$];

	// predictor copy of the configuration
	logic             square_on = 1'b1;
	logic [DIM_W-1:0] mask_w = DIM_W'(MAX_DIM);
	logic [DIM_W-1:0] img_w = DIM_W'(MAX_DIM);
	logic [DIM_W-1:0] img_h = DIM_W'(MAX_DIM);

	// predictor copy of the frame state
	logic [COORD_W-1:0] col_cnt = '0;
	logic [COORD_W-1:0] row_cnt = '0;
	logic [COORD_W-1:0] min_c = '1;
	logic [COORD_W-1:0] max_c = '0;
	logic [COORD_W-1:0] min_r = '1;
	logic [COORD_W-1:0] max_r = '0;
	logic               box_seen = 1'b0;

	int     err_cnt = 0;
	int     idle_pct = 24;
	int     hold_req = 0;
	int     hold_ack = 0;
	int     hold_left = 0;
	int     stall_cnt = 0;
	logic   in_taken = 1'b0;
	pixel_t next_px;
	crop_t  want;

	mask_bounding_box_square_crop_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mask_set    (mask_set),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.left_edge   (left_edge),
		.top_edge    (top_edge),
		.right_edge  (right_edge),
		.bottom_edge (bottom_edge)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// zero or oversized dimension acts as the largest one
	function automatic int dim_of(input logic [DIM_W-1:0] v);
		if (v == '0 || v > DIM_W'(MAX_DIM)) begin
			return MAX_DIM;
		end
		return int'(v);
	endfunction

	function automatic logic [COORD_W-1:0] clip_edge(input int v, input int dim);
		if (v < 0) begin
			return '0;
		end
		if (v > dim - 1) begin
			return COORD_W'(dim - 1);
		end
		return COORD_W'(v);
	endfunction

	// box tracking for one accepted pixel, crop prediction on frame end
	task automatic take_pixel(input logic set_px, input logic last_px);
		int    l, r, t, b, h, w, d;
		crop_t res;
		if (set_px) begin
			if (!box_seen) begin
				min_c = col_cnt;
				max_c = col_cnt;
				min_r = row_cnt;
				max_r = row_cnt;
				box_seen = 1'b1;
			end else begin
				if (col_cnt < min_c) min_c = col_cnt;
				if (col_cnt > max_c) max_c = col_cnt;
				if (row_cnt < min_r) min_r = row_cnt;
				if (row_cnt > max_r) max_r = row_cnt;
			end
		end
		if (!last_px) begin
			if (int'(col_cnt) + 1 >= dim_of(mask_w)) begin
				col_cnt = '0;
				if (int'(row_cnt) < MAX_DIM - 1) row_cnt++;
			end else begin
				col_cnt++;
			end
		end else begin
			res = '0;
			if (box_seen) begin
				l = int'(min_c);
				r = int'(max_c);
				t = int'(min_r);
				b = int'(max_r);
				// widen the shorter side on both ends
				if (square_on) begin
					h = b - t + 1;
					w = r - l + 1;
					if (h > w) begin
						d = (h - w) / 2;
						r += d;
						l -= d;
					end else begin
						d = (w - h) / 2;
						b += d;
						t -= d;
					end
				end
				res.found = 1'b1;
				res.left_edge = clip_edge(l, dim_of(img_w));
				res.right_edge = clip_edge(r, dim_of(img_w));
				res.top_edge = clip_edge(t, dim_of(img_h));
				res.bottom_edge = clip_edge(b, dim_of(img_h));
			end
			crop_q.push_back(res);
			col_cnt = '0;
			row_cnt = '0;
			min_c = '1;
			max_c = '0;
			min_r = '1;
			max_r = '0;
			box_seen = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	// register write while the core is idle
	task automatic write_reg(input cfg_idx_t idx, input int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= DIM_W'(val);
		case (idx)
			CFG_FIXED_ASPECT: square_on = val[0];
			CFG_MASK_WIDTH:   mask_w = DIM_W'(val);
			CFG_IMAGE_WIDTH:  img_w = DIM_W'(val);
			default:          img_h = DIM_W'(val);
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input int fa, input int mw, input int iw, input int ih);
		write_reg(CFG_FIXED_ASPECT, fa);
		write_reg(CFG_MASK_WIDTH, mw);
		write_reg(CFG_IMAGE_WIDTH, iw);
		write_reg(CFG_IMAGE_HEIGHT, ih);
	endtask

	task automatic queue_pixel(input logic m, input logic f);
		pixel_q.push_back({m, f});
	endtask

	task automatic queue_frame(input int npix, input int density);
		for (int i = 0; i < npix; i++) begin
			queue_pixel($urandom_range(99) < density, i == npix - 1);
		end
	endtask

	// wait for every request to be taken and every crop to be seen
	task automatic settle();
		while (pixel_q.size() != 0 || in_valid || crop_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_dim(input int small_max);
		case ($urandom_range(7))
			0:       return 0;
			1:       return MAX_DIM;
			2:       return $urandom_range(8191, MAX_DIM + 1);
			default: return $urandom_range(small_max, 1);
		endcase
	endfunction

	function automatic int pick_density();
		case ($urandom_range(4))
			0:       return 0;
			1:       return 5;
			2:       return 30;
			3:       return 70;
			default: return 100;
		endcase
	endfunction

	// pixel request driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				next_px = pixel_q.pop_front();
				in_valid <= 1'b1;
				mask_set <= next_px.mask_set;
				frame_end <= next_px.frame_end;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// crop result receiver, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(99) >= idle_pct);
		end
	end

	// monitor: prediction on accepted pixels, checking of crops, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				take_pixel(mask_set, frame_end);
			end
			if (out_valid && out_ready) begin
				if (crop_q.size() == 0) begin
					$error("crop result with no prediction waiting");
					err_cnt++;
				end else begin
					want = crop_q.pop_front();
					check_field("found", want.found, found);
					check_field("left_edge", want.left_edge, left_edge);
					check_field("top_edge", want.top_edge, top_edge);
					check_field("right_edge", want.right_edge, right_edge);
					check_field("bottom_edge", want.bottom_edge, bottom_edge);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cnt = 0;
			end else begin
				stall_cnt++;
			end
			if (stall_cnt >= STALL_LIMIT) begin
				$display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int rand_items;
		int batch;
		int npix;
		int phase;
		rand_items = 0;
		phase = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty frame, single pixel, wide and tall boxes
		set_config(1, 4, MAX_DIM, MAX_DIM);
		queue_pixel(1'b0, 1'b0);
		queue_pixel(1'b0, 1'b0);
		queue_pixel(1'b0, 1'b1);
		queue_pixel(1'b1, 1'b1);
		queue_pixel(1'b1, 1'b0);
		queue_pixel(1'b0, 1'b0);
		queue_pixel(1'b0, 1'b0);
		queue_pixel(1'b1, 1'b1);
		for (int i = 0; i < 13; i++) begin
			queue_pixel(i == 1 || i == 12, i == 12);
		end
		settle();

		// directed: box beyond a narrow image, oversized register values
		set_config(0, 8191, 2, 8191);
		queue_pixel(1'b0, 1'b0);
		queue_pixel(1'b0, 1'b0);
		queue_pixel(1'b0, 1'b0);
		queue_pixel(1'b1, 1'b1);
		settle();

		// random frames under random settings
		while (rand_items < 450) begin
			set_config($urandom_range(1), pick_dim(12), pick_dim(40), pick_dim(40));
			idle_pct = (phase == 1) ? 0 : 24;
			if (phase == 2) hold_req++;
			batch = 0;
			while (batch < ((phase == 1) ? 120 : 60)) begin
				npix = (phase == 2) ? $urandom_range(3, 1) : $urandom_range(40, 1);
				queue_frame(npix, pick_density());
				batch += npix;
			end
			rand_items += batch;
			settle();
			phase++;
		end
		idle_pct = 24;

		if (err_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== mask_bounding_box_square_crop_core.f =====
src/mbbox_pkg.sv
src/mask_bounding_box_square_crop_core.sv
sim/tb_top.sv
